// ===== hdl/wme_pkg.sv =====
package wme_pkg;

    localparam int MAX_SEQ_LEN_DEF = 4096;
    localparam int CHAR_BITS_DEF   = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_LOAD_PATTERN = 2'd0;
    localparam logic [1:0] CMD_LOAD_TEXT    = 2'd1;
    localparam logic [1:0] CMD_EXTEND       = 2'd2;

    localparam logic REG_PATTERN_LEN = 1'b0;
    localparam logic REG_TEXT_LEN    = 1'b1;

    localparam logic [13:0] ANTIDIAG_MAX = 14'h3FFF;

    typedef enum logic [2:0] {
        OP_LOAD_P,
        OP_LOAD_T,
        OP_NULL,
        OP_PASS,
        OP_WALK
    } t_op;

    typedef struct packed {
        t_op                op;
        logic        [11:0] idx;
        logic        [7:0]  chr;
        logic        [12:0] h;
        logic        [14:0] v;
        logic signed [13:0] k;
        logic               wave_start;
    } t_job;

    typedef struct packed {
        logic [12:0] new_offset;
        logic        null_out;
        logic [13:0] max_antidiagonal;
    } t_result;

endpackage

// ===== hdl/wme_ram.sv =====
module wme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/wme_front.sv =====
module wme_front #(
    parameter int MAX_SEQ_LEN = wme_pkg::MAX_SEQ_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic        [1:0]  i_cmd,
    input  logic        [11:0] i_char_index,
    input  logic        [7:0]  i_char_value,
    input  logic signed [13:0] i_diagonal,
    input  logic        [12:0] i_start_offset,
    input  logic               i_offset_is_null,
    input  logic               i_wave_start,
    input  logic               i_job_pop,
    output logic               o_job_valid,
    output wme_pkg::t_job      o_job
);

    localparam logic [16:0] MAX_L = 17'(MAX_SEQ_LEN);

    wme_pkg::t_job              job;
    logic                       keep;
    logic                       idx_ok;
    logic signed [15:0]         v_full;
    logic                       push_en;
    logic                       pop_en;

    wme_pkg::t_job              r_mem [wme_pkg::QUEUE_DEPTH];
    logic [wme_pkg::QAW-1:0]    r_wr;
    logic [wme_pkg::QAW-1:0]    r_rd;
    logic [wme_pkg::QCW-1:0]    r_count;

    always_comb begin
        idx_ok = {5'b0, i_char_index} < MAX_L;
        v_full = $signed({3'b0, i_start_offset}) - $signed({{2{i_diagonal[13]}}, i_diagonal});

        job.op         = wme_pkg::OP_LOAD_P;
        job.idx        = i_char_index;
        job.chr        = i_char_value;
        job.h          = i_start_offset;
        job.v          = v_full[14:0];
        job.k          = i_diagonal;
        job.wave_start = i_wave_start;
        keep           = 1'b0;

        case (i_cmd)
            wme_pkg::CMD_LOAD_PATTERN: begin
                job.op = wme_pkg::OP_LOAD_P;
                keep   = idx_ok;
            end
            wme_pkg::CMD_LOAD_TEXT: begin
                job.op = wme_pkg::OP_LOAD_T;
                keep   = idx_ok;
            end
            wme_pkg::CMD_EXTEND: begin
                keep = 1'b1;
                if (i_offset_is_null) begin
                    job.op = wme_pkg::OP_NULL;
                end else if (v_full[15]) begin
                    job.op = wme_pkg::OP_PASS;
                end else begin
                    job.op = wme_pkg::OP_WALK;
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_full      = r_count == wme_pkg::QCW'(wme_pkg::QUEUE_DEPTH);
    assign o_job_valid = r_count != '0;
    assign o_job       = r_mem[r_rd];
    assign push_en     = i_push && !o_full && keep;
    assign pop_en      = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_en) begin
                r_wr <= r_wr + wme_pkg::QAW'(1);
            end
            if (pop_en) begin
                r_rd <= r_rd + wme_pkg::QAW'(1);
            end
            if (push_en && !pop_en) begin
                r_count <= r_count + wme_pkg::QCW'(1);
            end else if (pop_en && !push_en) begin
                r_count <= r_count - wme_pkg::QCW'(1);
            end
        end
    end

endmodule

// ===== hdl/wme_back.sv =====
module wme_back #(
    parameter int MAX_SEQ_LEN = wme_pkg::MAX_SEQ_LEN_DEF,
    parameter int CHAR_BITS   = wme_pkg::CHAR_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [12:0]      i_pattern_length,
    input  logic [12:0]      i_text_length,
    input  logic             i_job_valid,
    input  wme_pkg::t_job    i_job,
    output logic             o_job_pop,
    output logic             o_out_valid,
    output wme_pkg::t_result o_out,
    input  logic             i_out_pop
);

    localparam int          AW    = $clog2(MAX_SEQ_LEN);
    localparam logic [16:0] MAX_L = 17'(MAX_SEQ_LEN);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state             r_state, n_state;
    logic        [14:0] r_v, n_v;
    logic        [12:0] r_h, n_h;
    logic signed [13:0] r_k, n_k;
    logic        [13:0] r_max, n_max;
    logic               r_out_valid, n_out_valid;
    wme_pkg::t_result   r_out, n_out;

    logic [16:0]          plen;
    logic [16:0]          tlen;
    logic                 in_bounds;
    logic                 chars_eq;
    logic                 out_free;
    logic                 p_we;
    logic                 t_we;
    logic [AW-1:0]        p_raddr;
    logic [AW-1:0]        t_raddr;
    logic [CHAR_BITS-1:0] p_rdata;
    logic [CHAR_BITS-1:0] t_rdata;
    logic [13:0]          base_max;

    function automatic logic [13:0] raise_max(input logic [13:0] base,
                                              input logic [12:0] h,
                                              input logic signed [13:0] k);
        logic signed [15:0] anti;
        logic               up;
        anti = $signed({2'b0, h, 1'b0}) - $signed({{2{k[13]}}, k});
        if (anti > $signed({2'b0, wme_pkg::ANTIDIAG_MAX})) begin
            anti = $signed({2'b0, wme_pkg::ANTIDIAG_MAX});
        end
        up = (anti > 16'sd0) && (anti > $signed({2'b0, base}));
        return up ? anti[13:0] : base;
    endfunction

    wme_ram #(
        .WIDTH (CHAR_BITS),
        .DEPTH (MAX_SEQ_LEN)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (AW'(i_job.idx)),
        .i_wdata (i_job.chr[CHAR_BITS-1:0]),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    wme_ram #(
        .WIDTH (CHAR_BITS),
        .DEPTH (MAX_SEQ_LEN)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (AW'(i_job.idx)),
        .i_wdata (i_job.chr[CHAR_BITS-1:0]),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    assign plen = ({4'b0, i_pattern_length} > MAX_L) ? MAX_L : {4'b0, i_pattern_length};
    assign tlen = ({4'b0, i_text_length} > MAX_L) ? MAX_L : {4'b0, i_text_length};
    assign in_bounds = ({2'b0, r_v} < plen) && ({4'b0, r_h} < tlen);
    assign chars_eq  = p_rdata == t_rdata;
    assign out_free  = !r_out_valid || i_out_pop;
    assign base_max  = i_job.wave_start ? 14'd0 : r_max;

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_h         = r_h;
        n_k         = r_k;
        n_max       = r_max;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_pop;
        o_job_pop   = 1'b0;
        p_we        = 1'b0;
        t_we        = 1'b0;
        p_raddr     = AW'(i_job.v);
        t_raddr     = AW'(i_job.h);

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.op)
                        wme_pkg::OP_LOAD_P: begin
                            p_we      = 1'b1;
                            o_job_pop = 1'b1;
                        end
                        wme_pkg::OP_LOAD_T: begin
                            t_we      = 1'b1;
                            o_job_pop = 1'b1;
                        end
                        wme_pkg::OP_NULL: begin
                            if (out_free) begin
                                o_job_pop              = 1'b1;
                                n_max                  = base_max;
                                n_out_valid            = 1'b1;
                                n_out.new_offset       = i_job.h;
                                n_out.null_out         = 1'b1;
                                n_out.max_antidiagonal = base_max;
                            end
                        end
                        wme_pkg::OP_PASS: begin
                            if (out_free) begin
                                o_job_pop              = 1'b1;
                                n_max                  = raise_max(base_max, i_job.h, i_job.k);
                                n_out_valid            = 1'b1;
                                n_out.new_offset       = i_job.h;
                                n_out.null_out         = 1'b0;
                                n_out.max_antidiagonal = n_max;
                            end
                        end
                        wme_pkg::OP_WALK: begin
                            o_job_pop = 1'b1;
                            n_max     = base_max;
                            n_v       = i_job.v;
                            n_h       = i_job.h;
                            n_k       = i_job.k;
                            n_state   = S_WALK;
                        end
                        default: begin
                            o_job_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (in_bounds && chars_eq) begin
                    n_v = r_v + 15'd1;
                    n_h = r_h + 13'd1;
                end else if (out_free) begin
                    n_max                  = raise_max(r_max, r_h, r_k);
                    n_out_valid            = 1'b1;
                    n_out.new_offset       = r_h;
                    n_out.null_out         = 1'b0;
                    n_out.max_antidiagonal = n_max;
                    n_state                = S_IDLE;
                end
                p_raddr = AW'(n_v);
                t_raddr = AW'(n_h);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
            r_v         <= n_v;
            r_h         <= n_h;
            r_k         <= n_k;
            r_out       <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hdl/wavefront_match_extender.sv =====
// Match extender for wavefront alignment. Pattern and text characters are
// loaded one item at a time into two local stores; an extend item walks its
// diagonal forward over equal characters, bounded by the pattern and text
// lengths, and returns the new offset with the running maximum antidiagonal
// of the current wavefront. Items enter a four-entry queue, so the input
// side keeps taking items while the walker is busy, until the queue is
// full. A load or a null or out-of-range extend is handled without a walk;
// a walking extend reads its matched characters through the one read
// port of each character store. One result waits in an output register.
// Stores need no clearing after reset. The user must write the lengths
// over the register port while no item is in flight; the block does not check it.
module wavefront_match_extender #(
    parameter int MAX_SEQ_LEN = wme_pkg::MAX_SEQ_LEN_DEF,
    parameter int CHAR_BITS   = wme_pkg::CHAR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic        [1:0]  i_cmd,
    input  logic        [11:0] i_char_index,
    input  logic        [7:0]  i_char_value,
    input  logic signed [13:0] i_diagonal,
    input  logic        [12:0] i_start_offset,
    input  logic               i_offset_is_null,
    input  logic               i_wave_start,
    output logic               o_empty,
    input  logic               i_pop,
    output logic        [12:0] o_new_offset,
    output logic               o_null_out,
    output logic        [13:0] o_max_antidiagonal,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    logic [12:0]      r_pattern_length;
    logic [12:0]      r_text_length;
    logic             job_valid;
    logic             job_pop;
    wme_pkg::t_job    job;
    logic             out_valid;
    wme_pkg::t_result out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= '0;
            r_text_length    <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                wme_pkg::REG_PATTERN_LEN: r_pattern_length <= pwdata[12:0];
                wme_pkg::REG_TEXT_LEN:    r_text_length    <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            wme_pkg::REG_PATTERN_LEN: prdata = {19'b0, r_pattern_length};
            wme_pkg::REG_TEXT_LEN:    prdata = {19'b0, r_text_length};
            default:                  prdata = '0;
        endcase
    end

    wme_front #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_cmd            (i_cmd),
        .i_char_index     (i_char_index),
        .i_char_value     (i_char_value),
        .i_diagonal       (i_diagonal),
        .i_start_offset   (i_start_offset),
        .i_offset_is_null (i_offset_is_null),
        .i_wave_start     (i_wave_start),
        .i_job_pop        (job_pop),
        .o_job_valid      (job_valid),
        .o_job            (job)
    );

    wme_back #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN),
        .CHAR_BITS   (CHAR_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pattern_length (r_pattern_length),
        .i_text_length    (r_text_length),
        .i_job_valid      (job_valid),
        .i_job            (job),
        .o_job_pop        (job_pop),
        .o_out_valid      (out_valid),
        .o_out            (out),
        .i_out_pop        (i_pop)
    );

    assign o_empty            = !out_valid;
    assign o_new_offset       = out.new_offset;
    assign o_null_out         = out.null_out;
    assign o_max_antidiagonal = out.max_antidiagonal;

endmodule
